// ===== hdl/tce_pkg.sv =====
// shared opcode codes and result struct for the execute unit
package tce_pkg;

    // instruction opcodes; codes 14 and 15 behave as nop
    typedef enum logic [3:0] {
        CMD_NOP  = 4'd0,
        CMD_LOAD = 4'd1,
        CMD_ADD  = 4'd2,
        CMD_SUB  = 4'd3,
        CMD_CMP  = 4'd4,
        CMD_JE   = 4'd5,
        CMD_JNE  = 4'd6,
        CMD_JL   = 4'd7,
        CMD_JG   = 4'd8,
        CMD_JZ   = 4'd9,
        CMD_JNZ  = 4'd10,
        CMD_JLZ  = 4'd11,
        CMD_JUMP = 4'd12,
        CMD_HALT = 4'd13
    } cmd_t;

    // architectural effect of one executed instruction
    typedef struct packed {
        logic        wr_en;
        logic [31:0] wr_val;
        logic        zero_flag;
        logic        sign_flag;
        logic        halted;
    } exec_res_t;

endpackage

// ===== hdl/tce_regfile.sv =====
// register file memory with two synchronous read ports, valid bits and write bypass
module tce_regfile #(
    parameter int NUM_REGS = 16,
    parameter int IDX_W    = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_a_idx,
    input  logic             rd_a_ok,
    input  logic [IDX_W-1:0] rd_b_idx,
    input  logic             rd_b_ok,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_data,
    output logic [31:0]      rd_a_data,
    output logic [31:0]      rd_b_data
);

    logic [31:0]         mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [31:0]         q_a_reg;
    logic [31:0]         q_b_reg;
    logic [31:0]         byp_data_reg;
    logic                a_live_reg;
    logic                b_live_reg;
    logic                a_byp_reg;
    logic                b_byp_reg;

    // memory array: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            q_a_reg      <= mem_reg[rd_a_idx];
            q_b_reg      <= mem_reg[rd_b_idx];
            byp_data_reg <= wr_data;
        end
    end

    // per-entry written bits, cleared at reset so unwritten entries read zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // read qualifiers and same-edge write bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_live_reg <= 1'b0;
            b_live_reg <= 1'b0;
            a_byp_reg  <= 1'b0;
            b_byp_reg  <= 1'b0;
        end
        else if (rd_en)
        begin
            a_live_reg <= rd_a_ok && valid_reg[rd_a_idx];
            b_live_reg <= rd_b_ok && valid_reg[rd_b_idx];
            a_byp_reg  <= rd_a_ok && wr_en && (wr_idx == rd_a_idx);
            b_byp_reg  <= rd_b_ok && wr_en && (wr_idx == rd_b_idx);
        end
    end

    // operand selection
    assign rd_a_data = a_byp_reg ? byp_data_reg : (a_live_reg ? q_a_reg : 32'd0);
    assign rd_b_data = b_byp_reg ? byp_data_reg : (b_live_reg ? q_b_reg : 32'd0);

endmodule

// ===== hdl/tce_exec.sv =====
// instruction execution: alu, compare, branch decision and next pc
module tce_exec #(
    parameter int PC_BITS = 16
) (
    input  tce_pkg::cmd_t        cmd,
    input  logic [15:0]          op1,
    input  logic [31:0]          op2,
    input  logic                 dst_ok,
    input  logic [31:0]          src_a,
    input  logic [31:0]          src_b,
    input  logic [PC_BITS-1:0]   pc,
    input  logic                 zero_in,
    input  logic                 sign_in,
    input  logic                 halt_in,
    output tce_pkg::exec_res_t   res,
    output logic [PC_BITS-1:0]   pc_next
);

    logic               do_write;
    logic [31:0]        value;
    logic               take;
    logic               hold;
    logic [31:0]        target_wide;
    logic [PC_BITS-1:0] target;

    assign target_wide = {16'd0, op1};
    assign target      = target_wide[PC_BITS-1:0];

    // opcode decode and datapath
    always_comb
    begin
        do_write      = 1'b0;
        value         = 32'd0;
        take          = 1'b0;
        hold          = 1'b0;
        res.zero_flag = zero_in;
        res.sign_flag = sign_in;
        res.halted    = halt_in;
        unique case (cmd)
            tce_pkg::CMD_LOAD:
            begin
                value    = op2;
                do_write = dst_ok;
            end
            tce_pkg::CMD_ADD:
            begin
                value    = src_a + src_b;
                do_write = dst_ok;
            end
            tce_pkg::CMD_SUB:
            begin
                value    = src_a - src_b;
                do_write = dst_ok;
            end
            tce_pkg::CMD_CMP:
            begin
                res.zero_flag = (src_a == src_b);
                res.sign_flag = ($signed(src_a) < $signed(src_b));
            end
            tce_pkg::CMD_JE, tce_pkg::CMD_JZ:   take = zero_in;
            tce_pkg::CMD_JNE, tce_pkg::CMD_JNZ: take = !zero_in;
            tce_pkg::CMD_JL:                    take = sign_in;
            tce_pkg::CMD_JG:                    take = !sign_in;
            tce_pkg::CMD_JLZ:                   take = zero_in && sign_in;
            tce_pkg::CMD_JUMP:                  take = 1'b1;
            tce_pkg::CMD_HALT:
            begin
                res.halted = 1'b1;
                hold       = 1'b1;
            end
            default: ;
        endcase

        // write result, zeroed when nothing is written
        res.wr_en  = do_write;
        res.wr_val = do_write ? value : 32'd0;
    end

    // next program counter
    always_comb
    begin
        priority if (take)
            pc_next = target;
        else if (hold)
            pc_next = pc;
        else
            pc_next = pc + PC_BITS'(1);
    end

endmodule

// ===== hdl/toy_cpu_execute_unit.sv =====
// Execute unit for a small cpu: takes one decoded instruction per transaction and returns
// the pc, flags, halted state and register write it caused. It accepts one instruction
// every cycle with no bubbles while result_ready is high; results are registered. The
// register file is a synchronous memory read at the acceptance edge; the instruction
// executes in the following cycle against the read data and writes back as it moves
// into the output register, with a same-edge bypass covering the next instruction's read.
// Register contents, pc and flags all read as zero after reset without a clearing pass.
module toy_cpu_execute_unit #(
    parameter int NUM_REGS = 16,
    parameter int PC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    output logic               instr_ready,
    input  logic [3:0]         command,
    input  logic [15:0]        first_operand,
    input  logic signed [31:0] second_operand,
    input  logic [3:0]         third_operand,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [15:0]        next_pc,
    output logic               zero_flag,
    output logic               sign_flag,
    output logic               halted,
    output logic               write_enable,
    output logic [3:0]         write_index,
    output logic signed [31:0] write_value
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic                 accept;
    logic                 s1_adv;
    logic                 is_cmp;
    logic [31:0]          idx_a_wide;
    logic [31:0]          idx_b_wide;
    logic [31:0]          dst_wide;
    logic                 a_ok;
    logic                 b_ok;
    logic                 dst_ok;
    logic [31:0]          src_a;
    logic [31:0]          src_b;
    logic                 rf_wr;
    logic [PC_BITS-1:0]   pc_next;
    logic [31:0]          pc_wide;
    tce_pkg::exec_res_t   res;

    logic                 s1_valid_reg;
    tce_pkg::cmd_t        s1_cmd_reg;
    logic [15:0]          s1_op1_reg;
    logic [31:0]          s1_op2_reg;
    logic                 s1_dst_ok_reg;

    logic [PC_BITS-1:0]   pc_reg;
    logic                 zero_reg;
    logic                 sign_reg;
    logic                 halt_reg;

    logic                 out_valid_reg;
    logic [15:0]          out_pc_reg;
    logic                 out_zero_reg;
    logic                 out_sign_reg;
    logic                 out_halt_reg;
    logic                 out_we_reg;
    logic [3:0]           out_idx_reg;
    logic [31:0]          out_val_reg;

    // handshake and stage advance
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign instr_ready = !s1_valid_reg || s1_adv;
    assign accept      = instr_valid && instr_ready;

    // operand index decode at acceptance
    assign is_cmp     = (tce_pkg::cmd_t'(command) == tce_pkg::CMD_CMP);
    assign idx_a_wide = is_cmp ? {16'd0, first_operand} : second_operand;
    assign idx_b_wide = is_cmp ? second_operand : {28'd0, third_operand};
    assign dst_wide   = {16'd0, first_operand};
    assign a_ok       = (idx_a_wide < 32'(NUM_REGS));
    assign b_ok       = (idx_b_wide < 32'(NUM_REGS));
    assign dst_ok     = (dst_wide < 32'(NUM_REGS));

    // register file
    assign rf_wr = s1_adv && res.wr_en;

    tce_regfile #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_a_idx  (idx_a_wide[IDX_W-1:0]),
        .rd_a_ok   (a_ok),
        .rd_b_idx  (idx_b_wide[IDX_W-1:0]),
        .rd_b_ok   (b_ok),
        .wr_en     (rf_wr),
        .wr_idx    (s1_op1_reg[IDX_W-1:0]),
        .wr_data   (res.wr_val),
        .rd_a_data (src_a),
        .rd_b_data (src_b)
    );

    // execute stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (instr_ready)
        begin
            s1_valid_reg <= instr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= tce_pkg::cmd_t'(command);
            s1_op1_reg    <= first_operand;
            s1_op2_reg    <= second_operand;
            s1_dst_ok_reg <= dst_ok;
        end
    end

    // execution
    tce_exec #(
        .PC_BITS (PC_BITS)
    ) u_exec (
        .cmd     (s1_cmd_reg),
        .op1     (s1_op1_reg),
        .op2     (s1_op2_reg),
        .dst_ok  (s1_dst_ok_reg),
        .src_a   (src_a),
        .src_b   (src_b),
        .pc      (pc_reg),
        .zero_in (zero_reg),
        .sign_in (sign_reg),
        .halt_in (halt_reg),
        .res     (res),
        .pc_next (pc_next)
    );

    // architectural pc and flags, updated as an instruction retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            zero_reg <= 1'b0;
            sign_reg <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            pc_reg   <= pc_next;
            zero_reg <= res.zero_flag;
            sign_reg <= res.sign_flag;
            halt_reg <= res.halted;
        end
    end

    // output register
    assign pc_wide = 32'(pc_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pc_reg   <= pc_wide[15:0];
            out_zero_reg <= res.zero_flag;
            out_sign_reg <= res.sign_flag;
            out_halt_reg <= res.halted;
            out_we_reg   <= res.wr_en;
            out_idx_reg  <= res.wr_en ? s1_op1_reg[3:0] : 4'd0;
            out_val_reg  <= res.wr_val;
        end
    end

    assign result_valid = out_valid_reg;
    assign next_pc      = out_pc_reg;
    assign zero_flag    = out_zero_reg;
    assign sign_flag    = out_sign_reg;
    assign halted       = out_halt_reg;
    assign write_enable = out_we_reg;
    assign write_index  = out_idx_reg;
    assign write_value  = out_val_reg;

`ifndef SYNTHESIS
    // halted state never clears once set
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halted flag cleared");

    // empty execute stage always takes a transaction
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> instr_ready)
        else $error("execute stage empty but not ready");

    // register file is written only by a retiring instruction
    a_write_on_retire: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr |-> (s1_valid_reg && s1_adv && s1_dst_ok_reg))
        else $error("register write without retiring instruction");

    // result with no write carries zero index and value
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !write_enable) |-> (write_index == 4'd0 && write_value == 32'sd0))
        else $error("write fields nonzero without write");

    // halt keeps the pc
    a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_cmd_reg == tce_pkg::CMD_HALT) |=> (pc_reg == $past(pc_reg)))
        else $error("halt changed the pc");
`endif

endmodule
